// ===== rtl/quaternion_smallest_three_decoder_defines.svh =====
// Assertion macros shared by the smallest-three decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef QUATERNION_SMALLEST_THREE_DECODER_DEFINES_SVH
`define QUATERNION_SMALLEST_THREE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define QSTD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define QSTD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define QSTD_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define QSTD_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== rtl/qstd_pkg.sv =====
// Types, constants and the square-root step for the smallest-three decoder.
// No dependencies; imported by qstd_sqrt_pipe and the top level.
package qstd_pkg;

	localparam int unsigned COMP_W      = 15;
	localparam int unsigned QUAT_W      = 17;
	localparam int unsigned SQ_W        = 29;
	localparam int unsigned SUM_W       = 30;
	localparam int unsigned SCL_W       = 48;
	localparam int unsigned RAD_W       = 32;
	localparam int unsigned SQRT_STAGES = 8;

	// sqrt(2) in Q1.32, rounded; error is far below the rounding margin
	localparam logic [32:0] SQRT2_Q32   = 33'h1_6A09_E668;
	localparam logic [SCL_W-1:0] SCL_HALF = 48'h0000_8000_0000;
	// sum of squares above 2^29 makes 2^30 - 2*sum negative
	localparam logic [SUM_W-1:0] SUM_LIMIT = 30'h2000_0000;
	localparam logic [RAD_W-1:0] ONE_SQ    = 32'h4000_0000;

	// axis code: which slot receives the reconstructed component
	typedef enum logic [2:0] {
		AXIS_X = 3'd0,
		AXIS_Y = 3'd1,
		AXIS_Z = 3'd2,
		AXIS_W = 3'd3
	} axis_t;

	typedef struct packed {
		axis_t                    code;
		logic                     clamped;
		logic signed [QUAT_W-1:0] qa;
		logic signed [QUAT_W-1:0] qb;
		logic signed [QUAT_W-1:0] qc;
	} side_t;

	typedef struct packed {
		logic [RAD_W-1:0] rem;
		logic [RAD_W-1:0] root;
	} sqrt_st_t;

	// one digit of the restoring integer square root
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t cur, input logic [RAD_W-1:0] bitv);
		logic [RAD_W-1:0] trial;
		sqrt_st_t         nxt;
		trial = cur.root + bitv;
		if (cur.rem >= trial) begin
			nxt.rem  = cur.rem - trial;
			nxt.root = (cur.root >> 1) + bitv;
		end else begin
			nxt.rem  = cur.rem;
			nxt.root = cur.root >> 1;
		end
		return nxt;
	endfunction

endpackage

// ===== rtl/quaternion_smallest_three_decoder.sv =====
// Smallest-three rotation decoder: takes one packed rotation word per cycle while in_stall
// is low and returns a unit quaternion in 1/32768 units, registered at the output.
// The missing component comes from a 16-digit square root, spread two digits per stage
// over eight stages; front stages unpack, multiply and sum squares.
// Each stage holds its word until the next frees up, so bubbles are squeezed out.
// Depends on qstd_pkg, qstd_sqrt_pipe and the assertion macro header.
`include "quaternion_smallest_three_decoder_defines.svh"

module quaternion_smallest_three_decoder
	import qstd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               axis_code,
	input  logic [COMP_W-1:0]        comp_a,
	input  logic [COMP_W-1:0]        comp_b,
	input  logic [COMP_W-1:0]        comp_c,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [QUAT_W-1:0] quat_x,
	output logic signed [QUAT_W-1:0] quat_y,
	output logic signed [QUAT_W-1:0] quat_z,
	output logic signed [QUAT_W-1:0] quat_w,
	output logic                     valid_res,
	output logic                     radicand_clamped
);

	logic [2:0][COMP_W-1:0] comp_in;
	logic [2:0][COMP_W-1:0] mag_in;
	logic [2:0]             neg_in;

	// stage 1: magnitudes and signs
	logic                   v_s1;
	axis_t                  code_s1;
	logic [2:0][COMP_W-1:0] mag_s1;
	logic [2:0]             neg_s1;

	// stage 2: squares and sqrt(2) scaling products
	logic                   v_s2;
	axis_t                  code_s2;
	logic [2:0][SQ_W-1:0]   sq_s2;
	logic [2:0][SCL_W-1:0]  scl_s2;
	logic [2:0]             neg_s2;

	// stage 3: radicand and rounded components
	logic                   v_s3;
	logic [RAD_W-1:0]       rad_s3;
	side_t                  side_s3;
	side_t                  side_nxt;
	logic [SUM_W-1:0]       sum_sq;
	logic [RAD_W-1:0]       rad_nxt;
	logic [2:0][SCL_W-1:0]  scl_rnd;
	logic [2:0][COMP_W-1:0] qmag;
	logic signed [QUAT_W-1:0] qs [3];

	logic adv1, adv2, adv3, adv_out;

	logic             sq_in_stall;
	logic             sq_out_valid;
	logic             sq_out_stall;
	logic [RAD_W-1:0] sq_root;
	logic [RAD_W-1:0] sq_rem;
	side_t            sq_side;

	logic signed [QUAT_W-1:0] qw;
	logic signed [QUAT_W-1:0] x_nxt, y_nxt, z_nxt, w_nxt;
	logic                     vres_nxt, clamp_nxt;

	logic                     out_valid_q;
	logic signed [QUAT_W-1:0] x_q, y_q, z_q, w_q;
	logic                     vres_q, clamp_q;

	assign adv_out  = !out_valid_q || !out_stall;
	assign adv3     = !v_s3 || !sq_in_stall;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	assign comp_in = {comp_c, comp_b, comp_a};

	// d = c - 16384: top bit set means d >= 0
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_in[i] = !comp_in[i][COMP_W-1];
			mag_in[i] = comp_in[i][COMP_W-1] ? {1'b0, comp_in[i][COMP_W-2:0]}
			                                 : (15'd16384 - comp_in[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			code_s1 <= axis_t'(axis_code);
			mag_s1  <= mag_in;
			neg_s1  <= neg_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			code_s2 <= code_s1;
			neg_s2  <= neg_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]  <= SQ_W'(mag_s1[i] * mag_s1[i]);
				scl_s2[i] <= SCL_W'(mag_s1[i] * SQRT2_Q32);
			end
		end
	end

	always_comb begin
		sum_sq = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		rad_nxt = ONE_SQ - {1'b0, sum_sq, 1'b0};
		for (int i = 0; i < 3; i++) begin
			scl_rnd[i] = scl_s2[i] + SCL_HALF;
			qmag[i]    = scl_rnd[i][46:32];
			qs[i]      = neg_s2[i] ? -$signed({2'b00, qmag[i]}) : $signed({2'b00, qmag[i]});
		end
		side_nxt.code    = code_s2;
		side_nxt.clamped = (sum_sq > SUM_LIMIT);
		side_nxt.qa      = qs[0];
		side_nxt.qb      = qs[1];
		side_nxt.qc      = qs[2];
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			side_s3 <= side_nxt;
			rad_s3  <= side_nxt.clamped ? '0 : rad_nxt;
		end
	end

	qstd_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_stall  (sq_in_stall),
		.in_rad    (rad_s3),
		.in_side   (side_s3),
		.out_valid (sq_out_valid),
		.out_stall (sq_out_stall),
		.out_root  (sq_root),
		.out_rem   (sq_rem),
		.out_side  (sq_side)
	);

	assign sq_out_stall = !adv_out;

	// round to nearest: bump when remainder exceeds the floor root
	assign qw = $signed({1'b0, sq_root[15:0]}) + $signed({16'd0, (sq_rem > sq_root)});

	always_comb begin
		x_nxt     = '0;
		y_nxt     = '0;
		z_nxt     = '0;
		w_nxt     = '0;
		vres_nxt  = 1'b1;
		clamp_nxt = sq_side.clamped;
		case (sq_side.code)
			AXIS_X: begin
				x_nxt = qw;          y_nxt = sq_side.qa;
				z_nxt = sq_side.qb;  w_nxt = sq_side.qc;
			end
			AXIS_Y: begin
				x_nxt = sq_side.qa;  y_nxt = qw;
				z_nxt = sq_side.qb;  w_nxt = sq_side.qc;
			end
			AXIS_Z: begin
				x_nxt = -sq_side.qa; y_nxt = -sq_side.qb;
				z_nxt = -qw;         w_nxt = -sq_side.qc;
			end
			AXIS_W: begin
				x_nxt = sq_side.qa;  y_nxt = sq_side.qb;
				z_nxt = sq_side.qc;  w_nxt = qw;
			end
			default: begin
				vres_nxt  = 1'b0;
				clamp_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= sq_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && sq_out_valid) begin
			x_q     <= x_nxt;
			y_q     <= y_nxt;
			z_q     <= z_nxt;
			w_q     <= w_nxt;
			vres_q  <= vres_nxt;
			clamp_q <= clamp_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign quat_x           = x_q;
	assign quat_y           = y_q;
	assign quat_z           = z_q;
	assign quat_w           = w_q;
	assign valid_res        = vres_q;
	assign radicand_clamped = clamp_q;

	// backpressure only originates at the output
	`QSTD_ASSERT_IMPL(a_stall_origin, clk, arst_n, in_stall, out_valid && out_stall)
	`QSTD_ASSERT_IMPL(a_bad_code_zero, clk, arst_n, out_valid && !valid_res,
		(quat_x == '0) && (quat_y == '0) && (quat_z == '0) && (quat_w == '0) && !radicand_clamped)
	// a clamped radicand leaves the rebuilt slot at zero
	`QSTD_ASSERT_IMPL(a_clamp_zero, clk, arst_n, out_valid && radicand_clamped,
		(quat_x == '0) || (quat_y == '0) || (quat_z == '0) || (quat_w == '0))

endmodule

// ===== rtl/qstd_sqrt_pipe.sv =====
// Pipelined 16-digit integer square root, two digits per stage, with sideband.
// Depends on qstd_pkg and the shared assertion macro header.
`include "quaternion_smallest_three_decoder_defines.svh"

module qstd_sqrt_pipe
	import qstd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [RAD_W-1:0] in_rad,
	input  side_t            in_side,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [RAD_W-1:0] out_root,
	output logic [RAD_W-1:0] out_rem,
	output side_t            out_side
);

	sqrt_st_t                st_s   [SQRT_STAGES];
	side_t                   side_s [SQRT_STAGES];
	logic [SQRT_STAGES-1:0]  vld_s;

	sqrt_st_t                st_in   [SQRT_STAGES];
	side_t                   side_in [SQRT_STAGES];
	logic [SQRT_STAGES-1:0]  vld_in;
	logic [SQRT_STAGES:0]    adv;

	assign adv[SQRT_STAGES] = !out_stall;
	assign in_stall         = !adv[0];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [RAD_W-1:0] BIT_HI = 32'd1 << (30 - 4 * k);
		localparam logic [RAD_W-1:0] BIT_LO = 32'd1 << (28 - 4 * k);
		sqrt_st_t nxt;

		if (k == 0) begin : g_first
			assign st_in[k]   = '{rem: in_rad, root: '0};
			assign side_in[k] = in_side;
			assign vld_in[k]  = in_valid;
		end else begin : g_rest
			assign st_in[k]   = st_s[k-1];
			assign side_in[k] = side_s[k-1];
			assign vld_in[k]  = vld_s[k-1];
		end

		assign adv[k] = !vld_s[k] || adv[k+1];

		always_comb begin
			nxt = sqrt_step(sqrt_step(st_in[k], BIT_HI), BIT_LO);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && vld_in[k]) begin
				st_s[k]   <= nxt;
				side_s[k] <= side_in[k];
			end
		end
	end

	assign out_valid = vld_s[SQRT_STAGES-1];
	assign out_root  = st_s[SQRT_STAGES-1].root;
	assign out_rem   = st_s[SQRT_STAGES-1].rem;
	assign out_side  = side_s[SQRT_STAGES-1];

	// radicand never exceeds 2^30, so the root tops out at 2^15
	`QSTD_ASSERT_IMPL(a_root_range, clk, arst_n, out_valid, out_root <= 32'd32768)
	// remainder of a floor root is at most twice the root
	`QSTD_ASSERT_IMPL(a_rem_bound, clk, arst_n, out_valid, out_rem <= (out_root << 1))
	`QSTD_ASSERT_IMPL(a_zero_root, clk, arst_n, out_valid && (out_root == '0), out_rem == '0)

endmodule
